[rtl/prq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants, codes and types of the priority request queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  // default sizing
  localparam int CAPACITY_DEF      = 32;
  localparam int PRIORITY_BITS_DEF = 4;
  localparam int ID_BITS_DEF       = 8;

  // fixed port widths
  localparam int CMD_W    = 2;
  localparam int IN_ID_W  = 8;
  localparam int IN_PRI_W = 4;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_EXPIRE  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_STALE    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_MARKED   = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_t;

  // what the shared unit does with each slot during a sweep
  typedef enum logic [1:0] {
    OP_AGE_UP    = 2'd0,  // age held entries, find first free slot
    OP_FIND_URG  = 2'd1,  // find most urgent, newest on a tie
    OP_FIND_ID   = 2'd2,  // find newest entry with matching id
    OP_CLOSE_GAP = 2'd3   // pull older entries one rank closer
  } scan_op_t;

  typedef struct packed {
    logic take;   // slot becomes the current pick
    logic wr_en;  // write back the adjusted age
  } scan_rsp_t;

endpackage

[rtl/prq_slot_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_slot_mem
// Slot store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module prq_slot_mem #(
  parameter int DEPTH = prq_pkg::CAPACITY_DEF,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/prq_scan_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_scan_unit
// Shared compare and age adjust unit, applied to one slot per cycle.
// ----------------------------------------------------------------------------
module prq_scan_unit #(
  parameter int ID_BITS       = prq_pkg::ID_BITS_DEF,
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF,
  parameter int AGE_W         = 5
) (
  input  prq_pkg::scan_op_t        op,
  input  logic                     ent_valid,
  input  logic [ID_BITS-1:0]       ent_ident,
  input  logic [PRIORITY_BITS-1:0] ent_urg,
  input  logic [AGE_W-1:0]         ent_age,
  input  logic [ID_BITS-1:0]       key_id,
  input  logic                     have,
  input  logic [PRIORITY_BITS-1:0] best_urg,
  input  logic [AGE_W-1:0]         best_age,
  output prq_pkg::scan_rsp_t       rsp,
  output logic [AGE_W-1:0]         new_age
);

  logic urg_lt;
  logic urg_eq;
  logic age_lt;
  logic age_gt;

  // one set of urgency and age comparators, shared by the search and rank update sweeps
  assign urg_lt = ent_urg < best_urg;
  assign urg_eq = ent_urg == best_urg;
  assign age_lt = ent_age < best_age;
  assign age_gt = ent_age > best_age;

  always_comb begin
    rsp.take  = 1'b0;
    rsp.wr_en = 1'b0;
    new_age   = ent_age;
    unique case (op)
      prq_pkg::OP_AGE_UP: begin
        rsp.take  = !ent_valid && !have;
        rsp.wr_en = ent_valid;
        new_age   = ent_age + AGE_W'(1);
      end
      prq_pkg::OP_FIND_URG: begin
        rsp.take = ent_valid && (!have || urg_lt || (urg_eq && age_lt));
      end
      prq_pkg::OP_FIND_ID: begin
        rsp.take = ent_valid && (ent_ident == key_id) && (!have || age_lt);
      end
      prq_pkg::OP_CLOSE_GAP: begin
        // best_age carries the age of the removed entry here
        rsp.wr_en = ent_valid && age_gt;
        new_age   = ent_age - AGE_W'(1);
      end
      default: begin
        rsp.take  = 1'b0;
        rsp.wr_en = 1'b0;
      end
    endcase
  end

endmodule

[rtl/priority_request_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_request_queue
// Bounded priority queue of requests with expiry by id.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; busy stays high
// until its single result has been put out. The result is shown for exactly
// one cycle with out_valid high and must be captured then. An insert, expire
// or extract sweeps the slot store through one shared compare unit, one slot
// per cycle over its registered read port: an insert ages held entries in
// one sweep and then writes the new entry, an expire searches in one sweep,
// and an extract runs a search sweep then a rank update sweep. A full insert
// or the unused command code is answered without a sweep. Lower priority
// numbers are more urgent; on a tie the newest entry is served.
// ----------------------------------------------------------------------------
module priority_request_queue #(
  parameter int CAPACITY      = prq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF,
  parameter int ID_BITS       = prq_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [prq_pkg::CMD_W-1:0]     in_command,
  input  logic [prq_pkg::IN_ID_W-1:0]   in_request_id,
  input  logic [prq_pkg::IN_PRI_W-1:0]  in_request_priority,
  output logic                          out_valid,
  output logic [prq_pkg::STATUS_W-1:0]  out_status,
  output logic [prq_pkg::IN_ID_W-1:0]   out_id,
  output logic [prq_pkg::IN_PRI_W-1:0]  out_priority,
  output logic [prq_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AGE_W = IDX_W;
  localparam int ENT_W = ID_BITS + PRIORITY_BITS + AGE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INS_WR
  } state_t;

  state_t                   state_r;
  prq_pkg::scan_op_t        op_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     pend_r;
  logic [IDX_W-1:0]         pend_idx_r;
  logic                     have_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [AGE_W-1:0]         best_age_r;
  logic [PRIORITY_BITS-1:0] best_urg_r;
  logic [ID_BITS-1:0]       best_id_r;
  logic [ID_BITS-1:0]       key_id_r;
  logic [PRIORITY_BITS-1:0] key_pri_r;
  prq_pkg::status_t         res_status_r;
  logic [CNT_W-1:0]         held_count_r;
  logic [CAPACITY-1:0]      slot_valid_r;
  logic [CAPACITY-1:0]      slot_stale_r;

  logic                     out_valid_r;
  prq_pkg::status_t         out_status_r;
  logic [ID_BITS-1:0]       out_id_r;
  logic [PRIORITY_BITS-1:0] out_pri_r;

  // input masking and output widening
  logic [ID_BITS+prq_pkg::IN_ID_W-1:0]        in_id_ext;
  logic [PRIORITY_BITS+prq_pkg::IN_PRI_W-1:0] in_pri_ext;
  logic [ID_BITS+prq_pkg::IN_ID_W-1:0]        out_id_ext;
  logic [PRIORITY_BITS+prq_pkg::IN_PRI_W-1:0] out_pri_ext;
  logic [CNT_W+prq_pkg::OCC_W-1:0]            occ_ext;

  assign in_id_ext   = {{ID_BITS{1'b0}}, in_request_id};
  assign in_pri_ext  = {{PRIORITY_BITS{1'b0}}, in_request_priority};
  assign out_id_ext  = {{prq_pkg::IN_ID_W{1'b0}}, out_id_r};
  assign out_pri_ext = {{prq_pkg::IN_PRI_W{1'b0}}, out_pri_r};
  assign occ_ext     = {{prq_pkg::OCC_W{1'b0}}, held_count_r};

  // handshake
  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // slot store
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [ENT_W-1:0] mem_rdata;

  logic [ID_BITS-1:0]       rd_ident;
  logic [PRIORITY_BITS-1:0] rd_urg;
  logic [AGE_W-1:0]         rd_age;
  logic [AGE_W-1:0]         new_age;
  prq_pkg::scan_rsp_t       rsp;
  logic                     scan_done;

  assign rd_ident = mem_rdata[ENT_W-1 -: ID_BITS];
  assign rd_urg   = mem_rdata[AGE_W +: PRIORITY_BITS];
  assign rd_age   = mem_rdata[AGE_W-1:0];

  assign mem_re    = (state_r == S_SCAN) && (cnt_r != CNT_W'(CAPACITY));
  assign scan_done = (state_r == S_SCAN) && (cnt_r == CNT_W'(CAPACITY)) && !pend_r;

  // write port: new entry on insert, adjusted age during a sweep
  always_comb begin
    if (state_r == S_INS_WR) begin
      mem_we    = have_r;
      mem_waddr = best_idx_r;
      mem_wdata = {key_id_r, key_pri_r, AGE_W'(0)};
    end else begin
      mem_we    = (state_r == S_SCAN) && pend_r && rsp.wr_en;
      mem_waddr = pend_idx_r;
      mem_wdata = {rd_ident, rd_urg, new_age};
    end
  end

  prq_slot_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  prq_scan_unit #(
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .AGE_W         (AGE_W)
  ) u_scan (
    .op        (op_r),
    .ent_valid (slot_valid_r[pend_idx_r]),
    .ent_ident (rd_ident),
    .ent_urg   (rd_urg),
    .ent_age   (rd_age),
    .key_id    (key_id_r),
    .have      (have_r),
    .best_urg  (best_urg_r),
    .best_age  (best_age_r),
    .rsp       (rsp),
    .new_age   (new_age)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      held_count_r <= '0;
      slot_valid_r <= '0;
      slot_stale_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_id_r   <= in_id_ext[ID_BITS-1:0];
            key_pri_r  <= in_pri_ext[PRIORITY_BITS-1:0];
            cnt_r      <= '0;
            pend_r     <= 1'b0;
            have_r     <= 1'b0;
            unique case (prq_pkg::cmd_t'(in_command))
              prq_pkg::CMD_INSERT: begin
                if (held_count_r >= CNT_W'(CAPACITY)) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= prq_pkg::ST_FULL;
                  out_id_r     <= '0;
                  out_pri_r    <= '0;
                end else begin
                  op_r    <= prq_pkg::OP_AGE_UP;
                  state_r <= S_SCAN;
                end
              end
              prq_pkg::CMD_EXTRACT: begin
                op_r    <= prq_pkg::OP_FIND_URG;
                state_r <= S_SCAN;
              end
              prq_pkg::CMD_EXPIRE: begin
                op_r    <= prq_pkg::OP_FIND_ID;
                state_r <= S_SCAN;
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= prq_pkg::ST_NOTFOUND;
                out_id_r     <= '0;
                out_pri_r    <= '0;
              end
            endcase
          end
        end

        S_SCAN: begin
          // read pipeline: one slot issued, the previous one evaluated
          pend_r     <= mem_re;
          pend_idx_r <= cnt_r[IDX_W-1:0];
          if (mem_re) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (pend_r && rsp.take) begin
            have_r     <= 1'b1;
            best_idx_r <= pend_idx_r;
            best_age_r <= rd_age;
            best_urg_r <= rd_urg;
            best_id_r  <= rd_ident;
          end
          // end of sweep
          if (scan_done) begin
            unique case (op_r)
              prq_pkg::OP_AGE_UP: begin
                state_r <= S_INS_WR;
              end
              prq_pkg::OP_FIND_URG: begin
                if (!have_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= prq_pkg::ST_EMPTY;
                  out_id_r     <= '0;
                  out_pri_r    <= '0;
                  state_r      <= S_IDLE;
                end else begin
                  res_status_r <= slot_stale_r[best_idx_r] ? prq_pkg::ST_STALE
                                                           : prq_pkg::ST_SERVED;
                  slot_valid_r[best_idx_r] <= 1'b0;
                  slot_stale_r[best_idx_r] <= 1'b0;
                  held_count_r <= held_count_r - CNT_W'(1);
                  op_r         <= prq_pkg::OP_CLOSE_GAP;
                  cnt_r        <= '0;
                end
              end
              prq_pkg::OP_FIND_ID: begin
                out_valid_r <= 1'b1;
                out_id_r    <= '0;
                out_pri_r   <= '0;
                if (have_r) begin
                  slot_stale_r[best_idx_r] <= 1'b1;
                  out_status_r <= prq_pkg::ST_MARKED;
                end else begin
                  out_status_r <= prq_pkg::ST_NOTFOUND;
                end
                state_r <= S_IDLE;
              end
              prq_pkg::OP_CLOSE_GAP: begin
                out_valid_r  <= 1'b1;
                out_status_r <= res_status_r;
                out_id_r     <= best_id_r;
                out_pri_r    <= best_urg_r;
                state_r      <= S_IDLE;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end

        S_INS_WR: begin
          // entry written into the first free slot this cycle
          out_valid_r <= 1'b1;
          out_id_r    <= '0;
          out_pri_r   <= '0;
          if (have_r) begin
            slot_valid_r[best_idx_r] <= 1'b1;
            slot_stale_r[best_idx_r] <= 1'b0;
            held_count_r <= held_count_r + CNT_W'(1);
            out_status_r <= prq_pkg::ST_INSERTED;
          end else begin
            out_status_r <= prq_pkg::ST_FULL;
          end
          state_r <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result ports
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_ext[prq_pkg::IN_ID_W-1:0];
  assign out_priority  = out_pri_ext[prq_pkg::IN_PRI_W-1:0];
  assign out_occupancy = occ_ext[prq_pkg::OCC_W-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(slot_valid_r) == int'(held_count_r)))
    else $error("held count disagrees with valid slots");

  a_stale_held: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_stale_r & ~slot_valid_r) == '0)
    else $error("stale mark on an empty slot");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= CNT_W'(CAPACITY)))
    else $error("sweep counter out of range");

endmodule

[verif/tb_priority_request_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_request_queue
// Self-checking testbench for the priority request queue.
// ----------------------------------------------------------------------------
// Commands are sent over the start/busy handshake. Each accepted item is run
// through a behavioural copy of the queue held in the testbench, and the
// status, id, priority and occupancy it gives are queued. Every result strobe
// is compared with the oldest queued result.
// Directed tests cover the empty store, the unused command code, duplicate
// ids, priority ties, repeated expiry and a full store. Random traffic
// follows, in fill, drain, mixed and noise phases, with random sender gaps
// and a closing stretch without gaps.
// ----------------------------------------------------------------------------
module tb_priority_request_queue;

  localparam int CAPACITY     = prq_pkg::CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

  typedef struct {
    prq_pkg::status_t              status;
    logic [prq_pkg::IN_ID_W-1:0]   id;
    logic [prq_pkg::IN_PRI_W-1:0]  pri;
    logic [prq_pkg::OCC_W-1:0]     occ;
  } queue_result_t;

  typedef enum int {
    TM_FILL,
    TM_DRAIN,
    TM_MIXED,
    TM_NOISE
  } traffic_mode_t;

  // DUT connections, known from time zero
  logic                           clk;
  logic                           rst_n               = 1'b0;
  logic                           start               = 1'b0;
  logic                           busy;
  logic [prq_pkg::CMD_W-1:0]      in_command          = '0;
  logic [prq_pkg::IN_ID_W-1:0]    in_request_id       = '0;
  logic [prq_pkg::IN_PRI_W-1:0]   in_request_priority = '0;
  logic                           out_valid;
  logic [prq_pkg::STATUS_W-1:0]   out_status;
  logic [prq_pkg::IN_ID_W-1:0]    out_id;
  logic [prq_pkg::IN_PRI_W-1:0]   out_priority;
  logic [prq_pkg::OCC_W-1:0]      out_occupancy;

  // behavioural copy of the slot store
  logic                           slot_used   [CAPACITY];
  logic                           slot_expired[CAPACITY];
  logic [prq_pkg::IN_ID_W-1:0]    slot_ident  [CAPACITY];
  logic [prq_pkg::IN_PRI_W-1:0]   slot_urgency[CAPACITY];
  int                             slot_rank   [CAPACITY];
  int                             held_count;

  queue_result_t                  pending_results[$];
  int                             error_count = 0;
  bit                             gaps_on     = 1'b0;

  priority_request_queue uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_request_id       (in_request_id),
    .in_request_priority (in_request_priority),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_id              (out_id),
    .out_priority        (out_priority),
    .out_occupancy       (out_occupancy)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Queue behaviour: applies one command to the local store, returns result
  // --------------------------------------------------------------------------
  function automatic queue_result_t apply_command(
    input prq_pkg::cmd_t                cmd,
    input logic [prq_pkg::IN_ID_W-1:0]  id,
    input logic [prq_pkg::IN_PRI_W-1:0] pri
  );
    queue_result_t res;
    int            pick;
    int            gone_rank;
    int            i;
    pick       = -1;
    res.status = prq_pkg::ST_NOTFOUND;
    res.id     = '0;
    res.pri    = '0;
    case (cmd)
      prq_pkg::CMD_INSERT: begin
        if (held_count >= CAPACITY) begin
          res.status = prq_pkg::ST_FULL;
        end else begin
          for (i = 0; i < CAPACITY; i++)
            if (!slot_used[i] && pick < 0) pick = i;
          // everything already held gets one rank older
          for (i = 0; i < CAPACITY; i++)
            if (slot_used[i]) slot_rank[i]++;
          slot_used[pick]    = 1'b1;
          slot_expired[pick] = 1'b0;
          slot_ident[pick]   = id;
          slot_urgency[pick] = pri;
          slot_rank[pick]    = 0;
          held_count++;
          res.status = prq_pkg::ST_INSERTED;
        end
      end
      prq_pkg::CMD_EXTRACT: begin
        // most urgent, newest on a tie
        for (i = 0; i < CAPACITY; i++) begin
          if (slot_used[i] && (pick < 0 || slot_urgency[i] < slot_urgency[pick] ||
              (slot_urgency[i] == slot_urgency[pick] && slot_rank[i] < slot_rank[pick])))
            pick = i;
        end
        if (pick < 0) begin
          res.status = prq_pkg::ST_EMPTY;
        end else begin
          res.status = slot_expired[pick] ? prq_pkg::ST_STALE : prq_pkg::ST_SERVED;
          res.id     = slot_ident[pick];
          res.pri    = slot_urgency[pick];
          gone_rank  = slot_rank[pick];
          slot_used[pick]    = 1'b0;
          slot_expired[pick] = 1'b0;
          for (i = 0; i < CAPACITY; i++)
            if (slot_used[i] && slot_rank[i] > gone_rank) slot_rank[i]--;
          held_count--;
        end
      end
      prq_pkg::CMD_EXPIRE: begin
        // newest entry carrying this id
        for (i = 0; i < CAPACITY; i++) begin
          if (slot_used[i] && slot_ident[i] == id &&
              (pick < 0 || slot_rank[i] < slot_rank[pick]))
            pick = i;
        end
        if (pick >= 0) begin
          slot_expired[pick] = 1'b1;
          res.status = prq_pkg::ST_MARKED;
        end
      end
      default: res.status = prq_pkg::ST_NOTFOUND;
    endcase
    res.occ = held_count[prq_pkg::OCC_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // idle burst, either straight after acceptance or once the block is free
  task automatic sender_gap();
    start <= 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      do @(posedge clk); while (busy === 1'b1);
    end
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  // present one item, hold until accepted, queue its result
  task automatic send_item(input prq_pkg::cmd_t cmd,
                           input logic [prq_pkg::IN_ID_W-1:0] id,
                           input logic [prq_pkg::IN_PRI_W-1:0] pri);
    start               <= 1'b1;
    in_command          <= cmd;
    in_request_id       <= id;
    in_request_priority <= pri;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_command(cmd, id, pri));
    if (gaps_on && $urandom_range(0, 3) == 0) sender_gap();
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d id %0d pri %0d occ %0d",
                 $time, out_status, out_id, out_priority, out_occupancy);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status || out_id !== exp_res.id ||
            out_priority !== exp_res.pri || out_occupancy !== exp_res.occ) begin
          error_count++;
          $display("%0t: exp st %0d id %0d pri %0d occ %0d, got st %0d id %0d pri %0d occ %0d",
                   $time, exp_res.status, exp_res.id, exp_res.pri, exp_res.occ,
                   out_status, out_id, out_priority, out_occupancy);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // empty store, expiry with nothing held, unused command code
  task automatic test_empty_store();
    send_item(prq_pkg::CMD_EXTRACT, 8'd0, 4'd0);
    send_item(prq_pkg::CMD_EXPIRE, 8'd0, 4'd0);
    send_item(prq_pkg::CMD_NOP, 8'hFF, 4'hF);
  endtask

  // duplicate ids, ties on priority, repeated expiry, extremes of fields
  task automatic test_ties_and_expiry();
    send_item(prq_pkg::CMD_INSERT, 8'hFF, 4'hF);
    send_item(prq_pkg::CMD_INSERT, 8'h00, 4'h0);
    send_item(prq_pkg::CMD_INSERT, 8'h5A, 4'h7);
    send_item(prq_pkg::CMD_INSERT, 8'h5A, 4'h7);
    send_item(prq_pkg::CMD_EXPIRE, 8'h5A, 4'h0);
    send_item(prq_pkg::CMD_EXPIRE, 8'h5A, 4'hF);   // already stale, same entry
    send_item(prq_pkg::CMD_EXPIRE, 8'hA5, 4'h0);   // no match
    send_item(prq_pkg::CMD_NOP, 8'h00, 4'h0);
    send_item(prq_pkg::CMD_EXTRACT, 8'hFF, 4'hF);
    send_item(prq_pkg::CMD_EXTRACT, 8'h00, 4'h0);  // newer duplicate, stale
    send_item(prq_pkg::CMD_EXTRACT, 8'h00, 4'h0);
    send_item(prq_pkg::CMD_EXTRACT, 8'h00, 4'h0);
    send_item(prq_pkg::CMD_EXTRACT, 8'h00, 4'h0);  // empty again
  endtask

  // fill every slot, bounce off the full store, then drain past empty
  task automatic test_store_full();
    int slot;
    gaps_on = 1'b1;
    while (held_count < CAPACITY)
      send_item(prq_pkg::CMD_INSERT, 8'($urandom_range(0, 255)),
                4'($urandom_range(0, 15)));
    send_item(prq_pkg::CMD_INSERT, 8'hFF, 4'h0);
    send_item(prq_pkg::CMD_INSERT, 8'h00, 4'hF);
    slot = $urandom_range(0, CAPACITY - 1);
    send_item(prq_pkg::CMD_EXPIRE, slot_ident[slot], 4'h0);
    send_item(prq_pkg::CMD_NOP, 8'h00, 4'h0);
    while (held_count > 0)
      send_item(prq_pkg::CMD_EXTRACT, 8'h00, 4'h0);
    send_item(prq_pkg::CMD_EXTRACT, 8'h00, 4'h0);
    gaps_on = 1'b0;
  endtask

  // phased random traffic; ids come mostly from a small pool so that expiry
  // hits held entries, priorities cluster so that ties are common
  task automatic test_random_traffic(input int n_items, input bit allow_gaps);
    traffic_mode_t                mode;
    int                           phase_left;
    int                           sent;
    int                           r;
    int                           slot;
    prq_pkg::cmd_t                cmd;
    logic [prq_pkg::IN_ID_W-1:0]  id;
    logic [prq_pkg::IN_PRI_W-1:0] pri;
    mode       = TM_MIXED;
    phase_left = 0;
    for (sent = 0; sent < n_items; sent++) begin
      if (phase_left == 0) begin
        r          = $urandom_range(0, 9);
        mode       = (r < 3) ? TM_FILL : (r < 6) ? TM_DRAIN : (r < 9) ? TM_MIXED : TM_NOISE;
        phase_left = $urandom_range(20, 70);
        gaps_on    = allow_gaps && ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      case (mode)
        TM_FILL:  cmd = (r < 80) ? prq_pkg::CMD_INSERT :
                        (r < 90) ? prq_pkg::CMD_EXPIRE : prq_pkg::CMD_EXTRACT;
        TM_DRAIN: cmd = (r < 75) ? prq_pkg::CMD_EXTRACT :
                        (r < 90) ? prq_pkg::CMD_EXPIRE : prq_pkg::CMD_INSERT;
        TM_MIXED: cmd = (r < 40) ? prq_pkg::CMD_INSERT :
                        (r < 75) ? prq_pkg::CMD_EXTRACT : prq_pkg::CMD_EXPIRE;
        default:  cmd = prq_pkg::cmd_t'($urandom_range(0, 3));
      endcase
      // id choice
      if (mode != TM_NOISE && cmd == prq_pkg::CMD_EXPIRE &&
          $urandom_range(0, 9) < 7) begin
        slot = $urandom_range(0, CAPACITY - 1);
        id   = slot_used[slot] ? slot_ident[slot] : 8'($urandom_range(0, 7));
      end else if (mode != TM_NOISE && $urandom_range(0, 1) == 1) begin
        id = 8'($urandom_range(0, 7));
      end else begin
        id = 8'($urandom_range(0, 255));
      end
      // priority choice
      case ($urandom_range(0, 3))
        0:       pri = 4'h0;
        1:       pri = 4'hF;
        2:       pri = 4'($urandom_range(6, 8));
        default: pri = 4'($urandom_range(0, 15));
      endcase
      send_item(cmd, id, pri);
    end
    gaps_on = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_used[i]    = 1'b0;
      slot_expired[i] = 1'b0;
      slot_ident[i]   = '0;
      slot_urgency[i] = '0;
      slot_rank[i]    = 0;
    end
    held_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_ties_and_expiry();
    test_store_full();
    test_random_traffic(850, 1'b1);
    test_random_traffic(150, 1'b0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
